### hdl/rc4ivp_pkg.sv
// shared types, codes and helpers for the iv-prefixed rc4 cipher
package rc4ivp_pkg;

  localparam int unsigned PERM_AW = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 64;

  typedef logic [PERM_AW-1:0] perm_addr_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       re;
    perm_addr_t raddr;
    logic       we;
    perm_addr_t waddr;
    byte_t      wdata;
  } mem_req_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_KINIT = 10'b00_0000_0010,
    ST_KRN   = 10'b00_0000_0100,
    ST_KRA   = 10'b00_0000_1000,
    ST_KW    = 10'b00_0001_0000,
    ST_KLAST = 10'b00_0010_0000,
    ST_DRI   = 10'b00_0100_0000,
    ST_DRJ   = 10'b00_1000_0000,
    ST_DSW   = 10'b01_0000_0000,
    ST_DOUT  = 10'b10_0000_0000
  } state_t;

  // schedule key byte: iv for the first sixteen positions, key repeated after
  function automatic byte_t sched_byte(input perm_addr_t n,
                                       input logic [2*WORD_W-1:0] iv,
                                       input logic [2*WORD_W-1:0] key);
    logic [6:0] base;
    base = {n[3:0], 3'b000};
    if (n[7:4] == 4'd0) begin
      return iv[base +: BYTE_W];
    end else begin
      return key[base +: BYTE_W];
    end
  endfunction

endpackage

### hdl/rc4ivp_if.sv
// valid/ready channel interfaces for input and result transactions
interface rc4ivp_in_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic [63:0] iv_low;
  logic [63:0] iv_high;
  logic [7:0]  data_in;

  modport source (output valid, output first, output iv_low, output iv_high,
                  output data_in, input ready);
  modport sink   (input valid, input first, input iv_low, input iv_high,
                  input data_in, output ready);
endinterface

interface rc4ivp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

### hdl/rc4_iv_prefixed_stream_cipher.sv
// rc4 cipher top level: sequencer, key registers and output register
// data byte: read, read, read-write, write on the single permutation memory in IDLE,
//   DRJ, DSW, DOUT; DOUT registers the result when output is free; next byte in IDLE
// first byte: key schedule before that, KINIT, then KRN, KRA, KW per entry, then KLAST, DRI
// reset: indices and keys zero, valid bits cleared at once so the permutation
//   reads as identity; no clearing pass
module rc4_iv_prefixed_stream_cipher
  import rc4ivp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  rc4ivp_in_if.sink           in_ch,
  rc4ivp_out_if.source        out_ch,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [WORD_W-1:0]   cfg_wdata
);

  state_t              st_r, st_nxt;
  perm_addr_t          i_r, i_nxt;
  perm_addr_t          j_r, j_nxt;
  byte_t               si_r, si_nxt;
  byte_t               sj_r, sj_nxt;
  perm_addr_t          sel_r, sel_nxt;
  byte_t               din_r, din_nxt;
  logic [2*WORD_W-1:0] iv_r, iv_nxt;
  logic [WORD_W-1:0]   key_lo_r, key_hi_r;
  logic                out_valid_r, out_valid_nxt;
  byte_t               out_data_r, out_data_nxt;

  mem_req_t            req;
  byte_t               rdata;
  perm_addr_t          acc;
  byte_t               z;
  logic                out_free;

  rc4ivp_perm_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  assign in_ch.ready     = (st_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_free        = !out_valid_r || out_ch.ready;

  always_comb begin
    st_nxt        = st_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    sel_nxt       = sel_r;
    din_nxt       = din_r;
    iv_nxt        = iv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    req           = '0;
    acc           = j_r + rdata + sched_byte(i_r, iv_r, {key_hi_r, key_lo_r});
    z             = (sel_r == i_r) ? sj_r : rdata;
    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          din_nxt = in_ch.data_in;
          iv_nxt  = {in_ch.iv_high, in_ch.iv_low};
          if (in_ch.first) begin
            st_nxt = ST_KINIT;
          end else begin
            req.re    = 1'b1;
            req.raddr = i_r + 8'd1;
            i_nxt     = i_r + 8'd1;
            st_nxt    = ST_DRJ;
          end
        end
      end
      ST_KINIT: begin
        req.clr = 1'b1;
        i_nxt   = '0;
        j_nxt   = '0;
        st_nxt  = ST_KRN;
      end
      ST_KRN: begin
        req.re    = 1'b1;
        req.raddr = i_r;
        // finish the previous swap
        if (i_r != '0) begin
          req.we    = 1'b1;
          req.waddr = j_r;
          req.wdata = si_r;
        end
        st_nxt = ST_KRA;
      end
      ST_KRA: begin
        si_nxt    = rdata;
        j_nxt     = acc;
        req.re    = 1'b1;
        req.raddr = acc;
        st_nxt    = ST_KW;
      end
      ST_KW: begin
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = rdata;
        if (i_r == '1) begin
          st_nxt = ST_KLAST;
        end else begin
          i_nxt  = i_r + 8'd1;
          st_nxt = ST_KRN;
        end
      end
      ST_KLAST: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = si_r;
        i_nxt     = '0;
        j_nxt     = '0;
        st_nxt    = ST_DRI;
      end
      ST_DRI: begin
        req.re    = 1'b1;
        req.raddr = i_r + 8'd1;
        i_nxt     = i_r + 8'd1;
        st_nxt    = ST_DRJ;
      end
      ST_DRJ: begin
        si_nxt    = rdata;
        j_nxt     = j_r + rdata;
        req.re    = 1'b1;
        req.raddr = j_r + rdata;
        st_nxt    = ST_DSW;
      end
      ST_DSW: begin
        sj_nxt    = rdata;
        sel_nxt   = si_r + rdata;
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = si_r;
        req.re    = 1'b1;
        req.raddr = si_r + rdata;
        st_nxt    = ST_DOUT;
      end
      ST_DOUT: begin
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = sj_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = z ^ din_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_LOW:  key_lo_r <= cfg_wdata;
          CFG_KEY_HIGH: key_hi_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    sel_r      <= sel_nxt;
    din_r      <= din_nxt;
    iv_r       <= iv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hdl/rc4ivp_perm_mem.sv
// permutation memory with per-entry valid bits and write-first forwarding
module rc4ivp_perm_mem
  import rc4ivp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output byte_t    rdata
);

  localparam int unsigned DEPTH = 1 << PERM_AW;

  byte_t             mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  byte_t             q_r;
  logic              qvld_r;
  perm_addr_t        qaddr_r;
  logic              col_r;
  byte_t             fwd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q_r     <= mem[req.raddr];
      qaddr_r <= req.raddr;
      fwd_r   <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      qvld_r <= 1'b0;
      col_r  <= 1'b0;
    end else begin
      if (req.re) begin
        qvld_r <= vld_r[req.raddr];
        col_r  <= req.we && (req.waddr == req.raddr);
      end
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
    end
  end

  // unwritten entries read as their own index
  assign rdata = col_r ? fwd_r : (qvld_r ? q_r : qaddr_r);

endmodule

### tb/tb_top.sv
// self-checking testbench for the iv-prefixed rc4 stream cipher
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4ivp_pkg::*;

  localparam int unsigned ITEM_TARGET    = 650;
  localparam int unsigned IDLE_PCT       = 13;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;

  class keystream_xor_tracker;
    byte_t             perm [256];
    byte_t             idx_i;
    byte_t             idx_j;
    logic [WORD_W-1:0] key_lo;
    logic [WORD_W-1:0] key_hi;
    byte_t             pending_cipher_bytes [$];
    int unsigned       mismatches;

    function new();
      for (int n = 0; n < 256; n++) perm[n] = byte_t'(n);
      idx_i      = '0;
      idx_j      = '0;
      key_lo     = '0;
      key_hi     = '0;
      mismatches = 0;
    endfunction

    function void set_key(logic index, logic [WORD_W-1:0] value);
      if (index == CFG_KEY_LOW) begin
        key_lo = value;
      end else begin
        key_hi = value;
      end
    endfunction

    function void swap_perm(byte_t a, byte_t b);
      byte_t t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    endfunction

    function void run_schedule(logic [WORD_W-1:0] iv_lo, logic [WORD_W-1:0] iv_hi);
      logic [2*WORD_W-1:0] iv_word;
      logic [2*WORD_W-1:0] key_word;
      byte_t               acc;
      byte_t               kb;
      iv_word  = {iv_hi, iv_lo};
      key_word = {key_hi, key_lo};
      acc      = '0;
      for (int n = 0; n < 256; n++) perm[n] = byte_t'(n);
      for (int n = 0; n < 256; n++) begin
        if (n < 16) begin
          kb = iv_word[8*n +: 8];
        end else begin
          kb = key_word[8*(n % 16) +: 8];
        end
        acc = acc + perm[n] + kb;
        swap_perm(byte_t'(n), acc);
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void note_input(logic first, logic [WORD_W-1:0] iv_lo,
                             logic [WORD_W-1:0] iv_hi, byte_t din);
      byte_t sel;
      if (first) run_schedule(iv_lo, iv_hi);
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      swap_perm(idx_i, idx_j);
      sel = perm[idx_i] + perm[idx_j];
      pending_cipher_bytes.push_back(perm[sel] ^ din);
    endfunction

    task report_mismatch(string what, byte_t got, byte_t want);
      if (mismatches < 200)
        $display("[%0t] mismatch: %s got %02h expected %02h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(byte_t dout);
      byte_t want;
      if (pending_cipher_bytes.size() == 0) begin
        report_mismatch("unexpected data_out", dout, 8'h00);
      end else begin
        want = pending_cipher_bytes.pop_front();
        if (dout !== want) report_mismatch("data_out", dout, want);
      end
    endtask

    function int unsigned pending();
      return pending_cipher_bytes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  rc4ivp_in_if  in_ch ();
  rc4ivp_out_if out_ch ();

  keystream_xor_tracker tracker = new();

  int unsigned items_sent;
  int unsigned hold_cycles;
  int unsigned stall_cycles;
  bit          no_idle;

  rc4_iv_prefixed_stream_cipher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] random_word64();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic offer_byte(input logic first, input logic [WORD_W-1:0] iv_lo,
                            input logic [WORD_W-1:0] iv_hi, input byte_t din);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.first   <= first;
    in_ch.iv_low  <= iv_lo;
    in_ch.iv_high <= iv_hi;
    in_ch.data_in <= din;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_input(first, iv_lo, iv_hi, din);
    items_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_key(input logic index, input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.set_key(index, value);
  endtask

  task automatic send_message(input int unsigned len);
    offer_byte(1'b1, random_word64(), random_word64(), byte_t'($urandom));
    repeat (len) offer_byte(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                            byte_t'($urandom));
  endtask

  // receiver: random stalls plus a long hold-off whenever one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) tracker.check_result(out_ch.data_out);
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_KEY_LOW;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.first   = 1'b0;
    in_ch.iv_low  = '0;
    in_ch.iv_high = '0;
    in_ch.data_in = '0;
    items_sent    = 0;
    hold_cycles   = 0;
    no_idle       = 1'b0;
    phase         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // keystream from the reset permutation, iv ignored without first
    offer_byte(1'b0, '0, '0, 8'h00);
    offer_byte(1'b0, '1, '1, 8'hFF);
    offer_byte(1'b1, '0, '0, 8'hA5);
    offer_byte(1'b0, '0, '0, 8'h5A);
    settle_idle();
    write_key(CFG_KEY_LOW, '1);
    write_key(CFG_KEY_HIGH, '0);
    // new key must not disturb the running message
    offer_byte(1'b0, '1, '0, 8'h3C);
    offer_byte(1'b1, '1, '1, 8'hFF);
    offer_byte(1'b0, '0, '1, 8'h00);
    settle_idle();
    write_key(CFG_KEY_HIGH, '1);
    write_key(CFG_KEY_LOW, '0);
    offer_byte(1'b1, 64'h0123_4567_89AB_CDEF, '0, 8'h80);
    offer_byte(1'b1, '0, 64'hFEDC_BA98_7654_3210, 8'h01);
    repeat (4) offer_byte(1'b0, '0, '0, byte_t'($urandom));
    settle_idle();
    write_key(CFG_KEY_LOW, '1);
    write_key(CFG_KEY_HIGH, '1);
    offer_byte(1'b1, '1, '1, 8'h00);
    offer_byte(1'b0, '1, '1, 8'hFF);

    while (items_sent < ITEM_TARGET) begin
      phase++;
      settle_idle();
      no_idle = (phase >= 4 && phase <= 7);
      if ($urandom_range(1)) begin
        write_key(CFG_KEY_LOW, random_word64());
        write_key(CFG_KEY_HIGH, random_word64());
      end else begin
        write_key(CFG_KEY_HIGH, random_word64());
        write_key(CFG_KEY_LOW, random_word64());
      end
      if (phase == 3 || phase == 12) begin
        // continue the current message while the receiver holds off
        hold_cycles = HOLD_CYCLES;
        repeat (24) offer_byte(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                               byte_t'($urandom));
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 90) begin
          send_message($urandom_range(0, 24));
        end else begin
          repeat ($urandom_range(1, 6))
            offer_byte(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                       byte_t'($urandom));
        end
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
